>>> hdl/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is off while the synchronous reset is active.
`define MTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion that pairs a condition with a required consequence in the same cycle.
`define MTS_ASSERT_IMP(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

`endif

>>> hdl/mts_pkg.sv
// Types, constants and helper functions of the task scheduler.
package mts_pkg;

  localparam int MAX_TASKS  = 32;
  localparam int MAX_CORES  = 8;
  localparam int SLOT_W     = $clog2(MAX_TASKS);
  localparam int CORE_W     = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int CORE_CNT_W = $clog2(MAX_CORES + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CORES = 2'd2;

  localparam logic [2:0] POL_FCFS       = 3'd0;
  localparam logic [2:0] POL_SJF        = 3'd1;
  localparam logic [2:0] POL_SRTF       = 3'd2;
  localparam logic [2:0] POL_SJF_P      = 3'd3;
  localparam logic [2:0] POL_FCFS_P     = 3'd4;
  localparam logic [2:0] POL_SRTF_P     = 3'd5;
  localparam logic [2:0] POL_PRIO_P     = 3'd6;
  localparam logic [2:0] POL_FROZEN     = 3'd7;

  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_ARRIVAL = 1'b1;
  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_ARRIVAL = 1'b1;

  localparam logic [2:0]  POLICY_RST  = POL_PRIO_P;
  localparam logic [7:0]  QUANTUM_RST = 8'd2;
  localparam logic [3:0]  CORES_RST   = 4'd1;
  localparam logic [15:0] RUN_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [15:0] ident;
    logic [7:0]  prio;
    logic [15:0] length;
    logic [15:0] left;
    logic [31:0] arrival;
  } rec_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREEMPT, ST_PCHK, ST_SCAN, ST_SCAN_END, ST_ASSIGN,
    ST_CNT_RD, ST_CNT_WR, ST_EMIT
  } state_t;

  typedef struct packed {
    logic              arrive;
    logic              preempt;
    logic              scan_start;
    logic              scan_rd;
    logic              assign_core;
    logic              cnt_rd;
    logic              cnt_wr;
    logic              emit;
    logic              last;
    logic [CORE_W-1:0] core;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic [CORE_CNT_W-1:0] n;
    logic [MAX_CORES-1:0]  core_valid;
    logic                  place_en;
  } stat_t;

  function automatic logic [CORE_CNT_W-1:0] cores_in_use(input logic [3:0] v);
    logic [CORE_CNT_W-1:0] r;
    if (v == 4'd0) begin
      r = CORE_CNT_W'(1);
    end else if (32'(v) > MAX_CORES) begin
      r = CORE_CNT_W'(MAX_CORES);
    end else begin
      r = CORE_CNT_W'(v);
    end
    return r;
  endfunction

  function automatic logic beats(input logic [2:0] pol, input rec_t b, input rec_t c);
    logic r;
    unique case (pol)
      POL_FCFS, POL_FCFS_P: r = c.arrival < b.arrival;
      POL_SJF, POL_SJF_P:   r = c.length < b.length;
      POL_SRTF, POL_SRTF_P: r = c.left < b.left;
      default: begin
        if (c.prio != b.prio) begin
          r = c.prio < b.prio;
        end else begin
          r = c.arrival < b.arrival;
        end
      end
    endcase
    return r;
  endfunction

endpackage

>>> hdl/multicore_task_scheduler_core.sv
// Top level of the multicore task scheduler: sequencer, datapath and checks.
// An arrival is taken while busy stays low and its acknowledgement word
// appears on the next cycle. A tick keeps busy high while it handles preemption,
// places tasks on the free cores in use, counts down and emits its reports;
// under policy seven no task is placed. Each free core that looks for a task
// scans the task table one slot a cycle through the single read port of the
// table memory. Tick report words follow one per cycle, core 0 first, each
// valid for exactly one cycle; the receiver cannot stall them.
// Configuration writes are always ready and must be made while busy is low.
module multicore_task_scheduler_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_mode,
  input  logic [15:0]                   in_task_id,
  input  logic [7:0]                    in_task_priority,
  input  logic [15:0]                   in_task_length,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mts_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          out_valid,
  output logic                          out_report_kind,
  output logic [2:0]                    out_core_index,
  output logic [15:0]                   out_running_id,
  output logic                          out_core_busy,
  output logic                          out_task_done,
  output logic                          out_accepted,
  output logic                          out_all_done,
  output logic [31:0]                   out_time_now,
  output logic                          out_last
);
  import mts_pkg::*;
  `include "assert_macros.svh"

  cmd_t  cmd;
  stat_t stat;
  logic  go;

  assign cfg_ready = 1'b1;
  assign go        = start & ~busy;

  mts_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (go),
    .in_mode (in_mode),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  mts_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_task_id       (in_task_id),
    .in_task_priority (in_task_priority),
    .in_task_length   (in_task_length),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_report_kind  (out_report_kind),
    .out_core_index   (out_core_index),
    .out_running_id   (out_running_id),
    .out_core_busy    (out_core_busy),
    .out_task_done    (out_task_done),
    .out_accepted     (out_accepted),
    .out_all_done     (out_all_done),
    .out_time_now     (out_time_now),
    .out_last         (out_last)
  );

  `MTS_ASSERT_IMP(a_ack_last, out_valid && out_report_kind, out_last, "ack word without last")
  `MTS_ASSERT(a_ack_follows, out_valid && out_report_kind |-> $past(go && in_mode), "stray ack word")
  `MTS_ASSERT_IMP(a_acc_kind, out_valid && out_accepted, out_report_kind, "tick word accepted")

endmodule

>>> hdl/mts_ctrl.sv
// Sequencer that takes arrivals and steps a tick through preemption, placement, countdown and reports.
module mts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_mode,
  input  mts_pkg::stat_t stat,
  output logic          busy,
  output mts_pkg::cmd_t cmd
);
  import mts_pkg::*;

  state_t                state_r, state_nxt;
  logic [CORE_CNT_W-1:0] core_r, core_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic                  core_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      core_r  <= '0;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      core_r  <= core_nxt;
      slot_r  <= slot_nxt;
    end
  end

  assign busy     = (state_r != ST_IDLE);
  assign core_end = ((core_r + CORE_CNT_W'(1)) == stat.n);

  always_comb begin
    state_nxt = state_r;
    core_nxt  = core_r;
    slot_nxt  = slot_r;
    cmd       = '0;
    cmd.core  = core_r[CORE_W-1:0];
    cmd.slot  = slot_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_mode == MODE_ARRIVAL) begin
            cmd.arrive = 1'b1;
          end else begin
            state_nxt = ST_PREEMPT;
          end
        end
      end
      ST_PREEMPT: begin
        cmd.preempt = 1'b1;
        core_nxt    = '0;
        state_nxt   = ST_PCHK;
      end
      ST_PCHK: begin
        if (!stat.place_en || core_r >= stat.n) begin
          core_nxt  = '0;
          state_nxt = ST_CNT_RD;
        end else if (stat.core_valid[core_r[CORE_W-1:0]]) begin
          core_nxt = core_r + CORE_CNT_W'(1);
        end else begin
          cmd.scan_start = 1'b1;
          slot_nxt       = '0;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (slot_r == SLOT_W'(MAX_TASKS - 1)) begin
          state_nxt = ST_SCAN_END;
        end else begin
          slot_nxt = slot_r + SLOT_W'(1);
        end
      end
      ST_SCAN_END: begin
        state_nxt = ST_ASSIGN;
      end
      ST_ASSIGN: begin
        cmd.assign_core = 1'b1;
        core_nxt        = core_r + CORE_CNT_W'(1);
        state_nxt       = ST_PCHK;
      end
      ST_CNT_RD: begin
        cmd.cnt_rd = 1'b1;
        state_nxt  = ST_CNT_WR;
      end
      ST_CNT_WR: begin
        cmd.cnt_wr = 1'b1;
        if (core_end) begin
          core_nxt  = '0;
          state_nxt = ST_EMIT;
        end else begin
          core_nxt  = core_r + CORE_CNT_W'(1);
          state_nxt = ST_CNT_RD;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        cmd.last = core_end;
        if (core_end) begin
          core_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          core_nxt = core_r + CORE_CNT_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> hdl/mts_dp.sv
// Task table, configuration registers, core state, selection compare and output word register.
module mts_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mts_pkg::cmd_t                     cmd,
  output mts_pkg::stat_t                    stat,
  input  logic [15:0]                       in_task_id,
  input  logic [7:0]                        in_task_priority,
  input  logic [15:0]                       in_task_length,
  input  logic                              cfg_valid,
  input  logic [mts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mts_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              out_valid,
  output logic                              out_report_kind,
  output logic [2:0]                        out_core_index,
  output logic [15:0]                       out_running_id,
  output logic                              out_core_busy,
  output logic                              out_task_done,
  output logic                              out_accepted,
  output logic                              out_all_done,
  output logic [31:0]                       out_time_now,
  output logic                              out_last
);
  import mts_pkg::*;

  rec_t mem [MAX_TASKS];
  rec_t rd_data_r;

  logic [2:0]  policy_r, policy_nxt;
  logic [7:0]  quantum_r, quantum_nxt;
  logic [3:0]  cores_r, cores_nxt;
  logic [31:0] tick_r, tick_nxt;

  logic [MAX_TASKS-1:0] occ_r, occ_nxt, run_r, run_nxt;
  logic [MAX_CORES-1:0] cv_r, cv_nxt;
  logic [SLOT_W-1:0]    cslot_r [MAX_CORES];
  logic [SLOT_W-1:0]    cslot_nxt [MAX_CORES];
  logic [15:0]          ccnt_r [MAX_CORES];
  logic [15:0]          ccnt_nxt [MAX_CORES];

  logic [15:0]          rep_id_r [MAX_CORES];
  logic [MAX_CORES-1:0] rep_busy_r, rep_done_r;

  logic              scan_q_r;
  logic [SLOT_W-1:0] scan_slot_q_r;
  logic              found_r, found_nxt;
  logic [SLOT_W-1:0] best_slot_r, best_slot_nxt;
  rec_t              best_r, best_nxt;

  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr, rd_addr, free_slot, cs;
  rec_t              wr_data;
  logic              free_ok, elig, preempt_pol;
  logic [CORE_CNT_W-1:0] n_cur, n_new;

  logic              ov_nxt, ok_q;

  assign n_cur          = cores_in_use(cores_r);
  assign n_new          = cores_in_use(cfg_data[3:0]);
  assign stat.n         = n_cur;
  assign stat.core_valid = cv_r;
  assign stat.place_en  = (policy_r != POL_FROZEN);
  assign preempt_pol    = (policy_r >= POL_SRTF) && (policy_r <= POL_PRIO_P);
  assign cs             = cslot_r[cmd.core];
  assign rd_addr        = cmd.cnt_rd ? cs : cmd.slot;
  assign elig           = occ_r[scan_slot_q_r] & ~run_r[scan_slot_q_r];

  always_comb begin
    free_ok   = 1'b0;
    free_slot = '0;
    for (int s = MAX_TASKS - 1; s >= 0; s--) begin
      if (!occ_r[s]) begin
        free_ok   = 1'b1;
        free_slot = SLOT_W'(s);
      end
    end
  end

  always_comb begin
    policy_nxt    = policy_r;
    quantum_nxt   = quantum_r;
    cores_nxt     = cores_r;
    tick_nxt      = tick_r;
    occ_nxt       = occ_r;
    run_nxt       = run_r;
    cv_nxt        = cv_r;
    cslot_nxt     = cslot_r;
    ccnt_nxt      = ccnt_r;
    found_nxt     = found_r;
    best_slot_nxt = best_slot_r;
    best_nxt      = best_r;
    wr_en         = 1'b0;
    wr_addr       = free_slot;
    wr_data       = rd_data_r;
    ok_q          = 1'b0;

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_POLICY:    policy_nxt  = cfg_data[2:0];
        CFG_QUANTUM:   quantum_nxt = cfg_data[7:0];
        CFG_NUM_CORES: begin
          cores_nxt = cfg_data[3:0];
          for (int c = 0; c < MAX_CORES; c++) begin
            if (CORE_CNT_W'(c) >= n_new) begin
              if (cv_r[c]) begin
                run_nxt[cslot_r[c]] = 1'b0;
              end
              cv_nxt[c]   = 1'b0;
              ccnt_nxt[c] = '0;
            end
          end
        end
        default: ;
      endcase
    end

    if (cmd.arrive && free_ok) begin
      ok_q                = 1'b1;
      wr_en               = 1'b1;
      wr_addr             = free_slot;
      wr_data.ident       = in_task_id;
      wr_data.prio        = in_task_priority;
      wr_data.length      = in_task_length;
      wr_data.left        = in_task_length;
      wr_data.arrival     = tick_r;
      occ_nxt[free_slot]  = 1'b1;
      run_nxt[free_slot]  = 1'b0;
    end

    if (cmd.preempt && preempt_pol) begin
      for (int c = 0; c < MAX_CORES; c++) begin
        if (CORE_CNT_W'(c) < n_cur && cv_r[c] && ccnt_r[c] >= {8'd0, quantum_r}) begin
          run_nxt[cslot_r[c]] = 1'b0;
          cv_nxt[c]           = 1'b0;
          ccnt_nxt[c]         = '0;
        end
      end
    end

    if (cmd.scan_start) begin
      found_nxt = 1'b0;
    end
    if (scan_q_r && elig && (!found_r || beats(policy_r, best_r, rd_data_r))) begin
      found_nxt     = 1'b1;
      best_slot_nxt = scan_slot_q_r;
      best_nxt      = rd_data_r;
    end

    if (cmd.assign_core && found_r) begin
      cv_nxt[cmd.core]     = 1'b1;
      cslot_nxt[cmd.core]  = best_slot_r;
      ccnt_nxt[cmd.core]   = '0;
      run_nxt[best_slot_r] = 1'b1;
    end

    if (cmd.cnt_wr && cv_r[cmd.core]) begin
      if (ccnt_r[cmd.core] != RUN_MAX) begin
        ccnt_nxt[cmd.core] = ccnt_r[cmd.core] + 16'd1;
      end
      wr_addr = cs;
      if (rd_data_r.left <= 16'd1) begin
        occ_nxt[cs]      = 1'b0;
        run_nxt[cs]      = 1'b0;
        cv_nxt[cmd.core] = 1'b0;
      end else begin
        wr_en        = 1'b1;
        wr_data.left = rd_data_r.left - 16'd1;
      end
    end

    if (cmd.emit && cmd.last) begin
      tick_nxt = tick_r + 32'd1;
    end
  end

  assign ov_nxt = cmd.arrive | cmd.emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r  <= POLICY_RST;
      quantum_r <= QUANTUM_RST;
      cores_r   <= CORES_RST;
      tick_r    <= 32'd1;
      occ_r     <= '0;
      run_r     <= '0;
      cv_r      <= '0;
      found_r   <= 1'b0;
      scan_q_r  <= 1'b0;
      out_valid <= 1'b0;
      for (int c = 0; c < MAX_CORES; c++) begin
        ccnt_r[c] <= '0;
      end
    end else begin
      policy_r  <= policy_nxt;
      quantum_r <= quantum_nxt;
      cores_r   <= cores_nxt;
      tick_r    <= tick_nxt;
      occ_r     <= occ_nxt;
      run_r     <= run_nxt;
      cv_r      <= cv_nxt;
      found_r   <= found_nxt;
      scan_q_r  <= cmd.scan_rd;
      out_valid <= ov_nxt;
      ccnt_r    <= ccnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r     <= mem[rd_addr];
    scan_slot_q_r <= cmd.slot;
    best_slot_r   <= best_slot_nxt;
    best_r        <= best_nxt;
    cslot_r       <= cslot_nxt;
    if (cmd.cnt_wr) begin
      rep_id_r[cmd.core]   <= cv_r[cmd.core] ? rd_data_r.ident : 16'd0;
      rep_busy_r[cmd.core] <= cv_r[cmd.core];
      rep_done_r[cmd.core] <= cv_r[cmd.core] && (rd_data_r.left <= 16'd1);
    end
    if (cmd.arrive) begin
      out_report_kind <= KIND_ARRIVAL;
      out_core_index  <= 3'd0;
      out_running_id  <= in_task_id;
      out_core_busy   <= 1'b0;
      out_task_done   <= 1'b0;
      out_accepted    <= ok_q;
      out_all_done    <= ~(|occ_r | ok_q);
      out_time_now    <= tick_r;
      out_last        <= 1'b1;
    end else if (cmd.emit) begin
      out_report_kind <= KIND_TICK;
      out_core_index  <= 3'(cmd.core);
      out_running_id  <= rep_id_r[cmd.core];
      out_core_busy   <= rep_busy_r[cmd.core];
      out_task_done   <= rep_done_r[cmd.core];
      out_accepted    <= 1'b0;
      out_all_done    <= ~|occ_r;
      out_time_now    <= tick_r;
      out_last        <= cmd.last;
    end
  end

endmodule

>>> test/multicore_task_scheduler_core_tb.sv
// Self-checking testbench for the multicore task scheduler core.
`timescale 1ns / 100ps

module multicore_task_scheduler_core_tb;
  import mts_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int NUM_SLOTS = MAX_TASKS;
  localparam int NUM_CORES = MAX_CORES;

  typedef struct packed {
    logic        kind;
    logic [2:0]  core;
    logic [15:0] rid;
    logic        cbusy;
    logic        done;
    logic        acc;
    logic        alld;
    logic [31:0] tnow;
    logic        last;
  } report_t;

  typedef struct {
    logic        mode;
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] len;
    bit          typed;
    bit          acc;
    bit          alld;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_mode;
  logic [15:0] in_task_id;
  logic [7:0] in_task_priority;
  logic [15:0] in_task_length;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic out_valid;
  logic out_report_kind;
  logic [2:0] out_core_index;
  logic [15:0] out_running_id;
  logic out_core_busy;
  logic out_task_done;
  logic out_accepted;
  logic out_all_done;
  logic [31:0] out_time_now;
  logic out_last;

  logic [2:0] sch_policy;
  logic [7:0] sch_quantum;
  logic [3:0] sch_cores;
  logic [15:0] tk_ident [NUM_SLOTS];
  logic [7:0] tk_prio [NUM_SLOTS];
  logic [15:0] tk_length [NUM_SLOTS];
  logic [15:0] tk_left [NUM_SLOTS];
  logic [31:0] tk_arrival [NUM_SLOTS];
  bit tk_occ [NUM_SLOTS];
  bit tk_run [NUM_SLOTS];
  int core_task [NUM_CORES];
  bit core_on [NUM_CORES];
  logic [15:0] core_ticks [NUM_CORES];
  logic [31:0] sch_time;

  report_t pending_reports[$];
  int mismatches;
  stim_row_t dir_rows [16];

  multicore_task_scheduler_core u_dut (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int active_cores();
    if (sch_cores == 4'd0) return 1;
    if (int'(sch_cores) > NUM_CORES) return NUM_CORES;
    return int'(sch_cores);
  endfunction

  function automatic bit table_idle();
    for (int s = 0; s < NUM_SLOTS; s++) if (tk_occ[s]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit outranks(int b, int c);
    case (sch_policy)
      POL_FCFS, POL_FCFS_P: return tk_arrival[c] < tk_arrival[b];
      POL_SJF, POL_SJF_P: return tk_length[c] < tk_length[b];
      POL_SRTF, POL_SRTF_P: return tk_left[c] < tk_left[b];
      default: begin
        if (tk_prio[c] != tk_prio[b]) return tk_prio[c] < tk_prio[b];
        return tk_arrival[c] < tk_arrival[b];
      end
    endcase
  endfunction

  function automatic void free_core(int c);
    if (core_on[c]) tk_run[core_task[c]] = 1'b0;
    core_on[c] = 1'b0;
    core_task[c] = 0;
    core_ticks[c] = '0;
  endfunction

  function automatic void schedule_reset();
    sch_policy = POLICY_RST;
    sch_quantum = QUANTUM_RST;
    sch_cores = CORES_RST;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      tk_occ[s] = 1'b0;
      tk_run[s] = 1'b0;
    end
    for (int c = 0; c < NUM_CORES; c++) begin
      core_on[c] = 1'b0;
      core_task[c] = 0;
      core_ticks[c] = '0;
    end
    sch_time = 32'd1;
  endfunction

  function automatic void schedule_config(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    case (idx)
      CFG_POLICY: sch_policy = val[2:0];
      CFG_QUANTUM: sch_quantum = val;
      CFG_NUM_CORES: begin
        sch_cores = val[3:0];
        for (int c = active_cores(); c < NUM_CORES; c++) free_core(c);
      end
      default: ;
    endcase
  endfunction

  function automatic void schedule_step(logic mode, logic [15:0] id, logic [7:0] prio,
                                        logic [15:0] len);
    report_t r;
    int n;
    int best;
    bit found;
    bit alld;
    report_t tick_reps [NUM_CORES];
    if (mode == MODE_ARRIVAL) begin
      r = '0;
      r.kind = KIND_ARRIVAL;
      r.rid = id;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (!tk_occ[s]) begin
          tk_ident[s] = id;
          tk_prio[s] = prio;
          tk_length[s] = len;
          tk_left[s] = len;
          tk_arrival[s] = sch_time;
          tk_occ[s] = 1'b1;
          tk_run[s] = 1'b0;
          r.acc = 1'b1;
          break;
        end
      end
      r.alld = table_idle();
      r.tnow = sch_time;
      r.last = 1'b1;
      pending_reports = {pending_reports, r};
      return;
    end
    n = active_cores();
    if (sch_policy >= POL_SRTF && sch_policy <= POL_PRIO_P) begin
      for (int c = 0; c < n; c++)
        if (core_on[c] && core_ticks[c] >= 16'(sch_quantum)) free_core(c);
    end
    if (sch_policy != POL_FROZEN) begin
      for (int c = 0; c < n; c++) begin
        if (!core_on[c]) begin
          found = 1'b0;
          best = 0;
          for (int s = 0; s < NUM_SLOTS; s++) begin
            if (tk_occ[s] && !tk_run[s] && (!found || outranks(best, s))) begin
              best = s;
              found = 1'b1;
            end
          end
          if (found) begin
            core_on[c] = 1'b1;
            core_task[c] = best;
            core_ticks[c] = '0;
            tk_run[best] = 1'b1;
          end
        end
      end
    end
    for (int c = 0; c < n; c++) begin
      r = '0;
      r.kind = KIND_TICK;
      r.core = 3'(c);
      r.tnow = sch_time;
      r.last = (c + 1 == n);
      if (core_on[c]) begin
        r.rid = tk_ident[core_task[c]];
        r.cbusy = 1'b1;
        if (core_ticks[c] != RUN_MAX) core_ticks[c]++;
        if (tk_left[core_task[c]] <= 16'd1) begin
          tk_left[core_task[c]] = '0;
          tk_occ[core_task[c]] = 1'b0;
          tk_run[core_task[c]] = 1'b0;
          core_on[c] = 1'b0;
          core_task[c] = 0;
          r.done = 1'b1;
        end else begin
          tk_left[core_task[c]]--;
        end
      end
      tick_reps[c] = r;
    end
    alld = table_idle();
    for (int c = 0; c < n; c++) begin
      tick_reps[c].alld = alld;
      pending_reports = {pending_reports, tick_reps[c]};
    end
    sch_time++;
  endfunction

  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst_n && out_valid) begin
      got = '{out_report_kind, out_core_index, out_running_id, out_core_busy,
              out_task_done, out_accepted, out_all_done, out_time_now, out_last};
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected word: %p", got);
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  task automatic send_item(logic mode, logic [15:0] id, logic [7:0] prio, logic [15:0] len,
                           bit typed, bit acc, bit alld);
    report_t r;
    start <= 1'b1;
    in_mode <= mode;
    in_task_id <= id;
    in_task_priority <= prio;
    in_task_length <= len;
    do @(posedge clk); while (busy);
    if (typed) begin
      r = '{KIND_ARRIVAL, 3'd0, id, 1'b0, 1'b0, acc, alld, sch_time, 1'b1};
      schedule_step(mode, id, prio, len);
      pending_reports[pending_reports.size() - 1] = r;
    end else begin
      schedule_step(mode, id, prio, len);
    end
  endtask

  task automatic pause_sender(ref int burst_left, input bit no_gaps);
    int gap;
    if (no_gaps) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 7);
    gap = $urandom_range(1, 6);
    start <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  task automatic drain_block();
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    schedule_config(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_item(int arrival_pct);
    logic [15:0] len;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) len = 16'($urandom_range(1, 6));
    else if (pick < 96) len = 16'($urandom_range(0, 40));
    else len = 16'($urandom);
    send_item(($urandom_range(0, 99) < arrival_pct) ? MODE_ARRIVAL : MODE_TICK,
              16'($urandom), 8'($urandom), len, 1'b0, 1'b0, 1'b0);
  endtask

  initial begin
    int burst_left;
    bit no_gaps;
    logic [7:0] pol_list [10];
    logic [7:0] qnt_list [10];
    logic [7:0] core_list [10];
    rst_n <= 1'b0;
    start <= 1'b0;
    in_mode <= 1'b0;
    in_task_id <= '0;
    in_task_priority <= '0;
    in_task_length <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    mismatches = 0;
    burst_left = 0;
    dir_rows = '{
      '{MODE_TICK, 16'h0, 8'h0, 16'h0, 0, 0, 0},
      '{MODE_ARRIVAL, 16'h0000, 8'h00, 16'h0000, 1, 1, 0},
      '{MODE_ARRIVAL, 16'hFFFF, 8'hFF, 16'hFFFF, 1, 1, 0},
      '{MODE_ARRIVAL, 16'h1234, 8'hFF, 16'h0003, 1, 1, 0},
      '{MODE_ARRIVAL, 16'h0042, 8'h00, 16'h0001, 1, 1, 0},
      '{MODE_TICK, 16'hFFFF, 8'hFF, 16'hFFFF, 0, 0, 0},
      '{MODE_TICK, 16'h0, 8'h0, 16'h0, 0, 0, 0},
      '{MODE_ARRIVAL, 16'hAAAA, 8'h55, 16'h0002, 0, 0, 0},
      '{MODE_ARRIVAL, 16'h5555, 8'h55, 16'h0002, 0, 0, 0},
      '{MODE_TICK, 16'h0, 8'h0, 16'h0, 0, 0, 0},
      '{MODE_TICK, 16'h0, 8'h0, 16'h0, 0, 0, 0},
      '{MODE_TICK, 16'h0, 8'h0, 16'h0, 0, 0, 0},
      '{MODE_TICK, 16'h0, 8'h0, 16'h0, 0, 0, 0},
      '{MODE_TICK, 16'h0, 8'h0, 16'h0, 0, 0, 0},
      '{MODE_TICK, 16'h0, 8'h0, 16'h0, 0, 0, 0},
      '{MODE_TICK, 16'h0, 8'h0, 16'h0, 0, 0, 0}
    };
    pol_list = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'hF8, 8'd6};
    qnt_list = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd3, 8'd1, 8'd0, 8'd5, 8'd2, 8'd1};
    core_list = '{8'd1, 8'd8, 8'd4, 8'd0, 8'd15, 8'd2, 8'd8, 8'd3, 8'd7, 8'hF5};
    schedule_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].mode, dir_rows[i].id, dir_rows[i].prio, dir_rows[i].len,
                dir_rows[i].typed, dir_rows[i].acc, dir_rows[i].alld);
      pause_sender(burst_left, 1'b0);
    end
    drain_block();

    write_reg(CFG_NUM_CORES, 8'd2);
    write_reg(CFG_QUANTUM, 8'd1);
    for (int i = 0; i < 34; i++)
      send_item(MODE_ARRIVAL, 16'($urandom), 8'($urandom), 16'($urandom_range(1, 3)),
                1'b0, 1'b0, 1'b0);
    for (int i = 0; i < 20; i++) begin
      random_item(10);
      pause_sender(burst_left, 1'b0);
    end
    drain_block();

    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_POLICY, pol_list[ph]);
      write_reg(CFG_QUANTUM, qnt_list[ph]);
      write_reg(CFG_NUM_CORES, core_list[ph]);
      write_reg(CFG_SPARE, 8'($urandom));
      no_gaps = (ph % 3 == 2);
      for (int i = 0; i < 45; i++) begin
        random_item((i < 15) ? 80 : 50);
        pause_sender(burst_left, no_gaps);
      end
      drain_block();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> multicore_task_scheduler_core.f
+incdir+hdl
hdl/mts_pkg.sv
hdl/mts_ctrl.sv
hdl/mts_dp.sv
hdl/multicore_task_scheduler_core.sv
test/multicore_task_scheduler_core_tb.sv
